@@ design/udsw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// udsw_pkg
// Shared types, limits and display helpers for the hh:mm:ss stopwatch.
// ----------------------------------------------------------------------------
package udsw_pkg;

  typedef enum logic [3:0] {
    CMD_TICK     = 4'd0,
    CMD_RESET    = 4'd1,
    CMD_PAUSE    = 4'd2,
    CMD_RESUME   = 4'd3,
    CMD_TOGGLE   = 4'd4,
    CMD_HOUR_INC = 4'd5,
    CMD_HOUR_DEC = 4'd6,
    CMD_MIN_INC  = 4'd7,
    CMD_MIN_DEC  = 4'd8,
    CMD_SEC_INC  = 4'd9,
    CMD_SEC_DEC  = 4'd10
  } cmd_t;

  localparam int SecW  = 6;
  localparam int MinW  = 6;
  localparam int HourW = 5;

  localparam logic [SecW-1:0]  SecMax     = 6'd59;
  localparam logic [SecW-1:0]  SecWrap    = 6'd60;
  localparam logic [MinW-1:0]  MinMax     = 6'd59;
  localparam logic [MinW-1:0]  MinWrap    = 6'd60;
  localparam logic [HourW-1:0] HourMax    = 5'd24;
  localparam logic [HourW-1:0] HourWrap   = 5'd24;
  localparam int               DigitRadix = 10;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] ones;
  } bcd_t;

  // Split a value below 64 into two decimal digits.
  function automatic bcd_t to_bcd(input logic [5:0] v);
    bcd_t       r;
    logic [2:0] t;
    if (v >= 6'd60) begin
      t = 3'd6;
    end else if (v >= 6'd50) begin
      t = 3'd5;
    end else if (v >= 6'd40) begin
      t = 3'd4;
    end else if (v >= 6'd30) begin
      t = 3'd3;
    end else if (v >= 6'd20) begin
      t = 3'd2;
    end else if (v >= 6'd10) begin
      t = 3'd1;
    end else begin
      t = 3'd0;
    end
    r.tens = t;
    r.ones = 4'(v - 6'(t * DigitRadix));
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/up_down_stopwatch_hms.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// up_down_stopwatch_hms
// Hours:minutes:seconds stopwatch with count-down mode and BCD display out.
//
//   channel | signals                                    | direction
//   --------+--------------------------------------------+----------
//   in      | in_valid, in_ready, command,               | into block
//           | mode_button_held                           |
//   out     | out_valid, out_ready, six BCD digits,      | out of block
//           | buzzer_on, red_led, yellow_led, is_paused,  |
//           | counting_down                              |
//
// One command per cycle; each accepted command updates the time and flag
// registers in the same cycle and its result shows on the next cycle.
// The result is the registered state, decoded to BCD on the way out.
// A stalled result blocks new commands only while out_ready is low.
// Synchronous reset clears the time, pause, mode and buzzer, lights red.
// ----------------------------------------------------------------------------
module up_down_stopwatch_hms import udsw_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [3:0] command,
  input  wire logic       mode_button_held,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [3:0]      sec_ones,
  output logic [2:0]      sec_tens,
  output logic [3:0]      min_ones,
  output logic [2:0]      min_tens,
  output logic [3:0]      hour_ones,
  output logic [1:0]      hour_tens,
  output logic            buzzer_on,
  output logic            red_led,
  output logic            yellow_led,
  output logic            is_paused,
  output logic            counting_down
);

  logic [SecW-1:0]  seconds, seconds_next, sec_plus;
  logic [MinW-1:0]  minutes, minutes_next, min_plus;
  logic [HourW-1:0] hours, hours_next, hour_plus;
  logic             paused, paused_next;
  logic             down_mode, down_mode_next;
  logic             buzzer, buzzer_next;
  logic             red, red_next;
  logic             yellow, yellow_next;
  logic             in_fire;
  bcd_t             sec_bcd, min_bcd, hour_bcd;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign sec_plus  = seconds + 1'b1;
  assign min_plus  = minutes + 1'b1;
  assign hour_plus = hours + 1'b1;

  always_comb begin
    seconds_next   = seconds;
    minutes_next   = minutes;
    hours_next     = hours;
    paused_next    = paused;
    down_mode_next = down_mode;
    buzzer_next    = buzzer;
    red_next       = red;
    yellow_next    = yellow;
    case (cmd_t'(command))
      CMD_TICK: begin
        if (!paused && down_mode) begin
          if (seconds != '0) begin
            seconds_next = seconds - 1'b1;
          end else if (minutes != '0) begin
            minutes_next = minutes - 1'b1;
            seconds_next = SecMax;
          end else if (hours != '0) begin
            hours_next   = hours - 1'b1;
            minutes_next = MinMax;
            seconds_next = SecMax;
          end else begin
            buzzer_next = 1'b1;
          end
        end else if (!paused) begin
          if (mode_button_held) begin
            red_next    = 1'b1;
            buzzer_next = 1'b0;
          end
          seconds_next = sec_plus;
          if (sec_plus >= SecWrap) begin
            seconds_next = '0;
            minutes_next = min_plus;
            if (min_plus >= MinWrap) begin
              minutes_next = '0;
              hours_next   = hour_plus;
              if (hour_plus >= HourWrap) begin
                hours_next = '0;
              end
            end
          end
        end
      end
      CMD_RESET: begin
        seconds_next = '0;
        minutes_next = '0;
        hours_next   = '0;
      end
      CMD_PAUSE: begin
        paused_next = 1'b1;
      end
      CMD_RESUME: begin
        paused_next = 1'b0;
        buzzer_next = 1'b0;
      end
      CMD_TOGGLE: begin
        if (paused) begin
          down_mode_next = !down_mode;
          red_next       = !red;
          yellow_next    = !yellow;
        end
      end
      CMD_HOUR_INC: begin
        if (paused && hours < HourMax) hours_next = hour_plus;
      end
      CMD_HOUR_DEC: begin
        if (paused && hours != '0) hours_next = hours - 1'b1;
      end
      CMD_MIN_INC: begin
        if (paused && minutes < MinMax) minutes_next = min_plus;
      end
      CMD_MIN_DEC: begin
        if (paused && minutes != '0) minutes_next = minutes - 1'b1;
      end
      CMD_SEC_INC: begin
        if (paused && seconds < SecMax) seconds_next = sec_plus;
      end
      CMD_SEC_DEC: begin
        if (paused && seconds != '0) seconds_next = seconds - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seconds   <= '0;
      minutes   <= '0;
      hours     <= '0;
      paused    <= 1'b0;
      down_mode <= 1'b0;
      buzzer    <= 1'b0;
      red       <= 1'b1;
      yellow    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        seconds   <= seconds_next;
        minutes   <= minutes_next;
        hours     <= hours_next;
        paused    <= paused_next;
        down_mode <= down_mode_next;
        buzzer    <= buzzer_next;
        red       <= red_next;
        yellow    <= yellow_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sec_bcd  = to_bcd(seconds);
  assign min_bcd  = to_bcd(minutes);
  assign hour_bcd = to_bcd({1'b0, hours});

  assign sec_ones      = sec_bcd.ones;
  assign sec_tens      = sec_bcd.tens;
  assign min_ones      = min_bcd.ones;
  assign min_tens      = min_bcd.tens;
  assign hour_ones     = hour_bcd.ones;
  assign hour_tens     = hour_bcd.tens[1:0];
  assign buzzer_on     = buzzer;
  assign red_led       = red;
  assign yellow_led    = yellow;
  assign is_paused     = paused;
  assign counting_down = down_mode;

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    seconds <= SecMax && minutes <= MinMax && hours <= HourMax)
    else $error("time out of range");

  a_led_mode: assert property (@(posedge clk) disable iff (rst)
    red == !down_mode && yellow == down_mode)
    else $error("mode LEDs disagree with mode");

  a_paused_tick: assert property (@(posedge clk) disable iff (rst)
    in_fire && paused && command == CMD_TICK |=>
      $stable(seconds) && $stable(minutes) && $stable(hours) && $stable(buzzer))
    else $error("tick changed state while paused");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(seconds) && $stable(minutes) && $stable(hours))
    else $error("stalled transaction changed");

  a_adjust_running: assert property (@(posedge clk) disable iff (rst)
    in_fire && !paused && command >= CMD_TOGGLE && command <= CMD_SEC_DEC |=>
      $stable(seconds) && $stable(minutes) && $stable(hours) && $stable(down_mode))
    else $error("adjust acted while running");

endmodule
`default_nettype wire
